### src/mwdto_pkg.sv
package mwdto_pkg;

   localparam int MAX_TASKS_DEFAULT = 8;
   localparam int DATA_W = 16;
   localparam int NUM_W = 4;
   localparam int COST_W = 39;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic store;
      logic start;
      logic step;
      logic emit_next;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic emit_end;
   } status_type;

endpackage

### src/min_weighted_delay_task_order.sv
// Tasks load at one item per cycle; the item with tlast starts a depth-first search.
// The search walks each edge of the order tree down and back up, one step per cycle.
// Results then leave at one item per cycle while rsp_tready is high, one per task, and a new set is taken after.
// Synchronous active-high reset clears the task count and returns to loading.
module min_weighted_delay_task_order
   import mwdto_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // task_duration[15:0], task_fine[31:16]
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // task_number[3:0], total_fine[42:4], zeros
   output logic                  rsp_tlast
);

   cmd_type           cmd;
   status_type        status;
   logic [NUM_W-1:0]  out_number;
   logic [COST_W-1:0] out_cost;

   mwdto_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   mwdto_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_duration (req_tdata[DATA_W-1:0]),
      .in_fine     (req_tdata[2*DATA_W-1:DATA_W]),
      .status      (status),
      .out_number  (out_number),
      .out_cost    (out_cost),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W - NUM_W - COST_W){1'b0}}, out_cost, out_number};

endmodule

### src/mwdto_ctrl.sv
module mwdto_ctrl
   import mwdto_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tlast) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.search_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready && status.emit_end) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.store = req_tvalid;
            cmd.start = req_tvalid && req_tlast;
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            cmd.emit_next = rsp_tready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### src/mwdto_datapath.sv
module mwdto_datapath
   import mwdto_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [DATA_W-1:0] in_duration,
   input  logic [DATA_W-1:0] in_fine,
   output status_type        status,
   output logic [NUM_W-1:0]  out_number,
   output logic [COST_W-1:0] out_cost,
   output logic              out_last
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int EL_W = DATA_W + IDX_W;
   localparam int PROD_W = EL_W + DATA_W;

   logic [DATA_W-1:0] dur_ff [MAX_TASKS];
   logic [DATA_W-1:0] fine_ff [MAX_TASKS];
   logic [DATA_W-1:0] dur_in [MAX_TASKS];
   logic [DATA_W-1:0] fine_in [MAX_TASKS];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [CNT_W-1:0]  cand_ff, cand_in;
   logic [MAX_TASKS-1:0] used_ff, used_in;
   logic [IDX_W-1:0]  trial_ff [MAX_TASKS];
   logic [IDX_W-1:0]  trial_in [MAX_TASKS];
   logic [IDX_W-1:0]  best_ff [MAX_TASKS];
   logic [IDX_W-1:0]  best_in [MAX_TASKS];
   logic [EL_W-1:0]   elapsed_ff [MAX_TASKS + 1];
   logic [EL_W-1:0]   elapsed_in [MAX_TASKS + 1];
   logic [COST_W-1:0] total_ff [MAX_TASKS + 1];
   logic [COST_W-1:0] total_in [MAX_TASKS + 1];
   logic [COST_W-1:0] best_cost_ff, best_cost_in;
   logic              first_ff, first_in;
   logic [IDX_W-1:0]  emit_ff, emit_in;

   logic              pick_found;
   logic [IDX_W-1:0]  pick_idx;
   logic              at_leaf;
   logic [CNT_W-1:0]  depth_m1;
   logic [IDX_W-1:0]  back_idx;
   logic [PROD_W-1:0] prod;
   logic              room;

   always_comb begin
      pick_found = 1'b0;
      pick_idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (!used_ff[i] && (CNT_W'(i) < n_ff) && (CNT_W'(i) >= cand_ff)) begin
            pick_found = 1'b1;
            pick_idx = IDX_W'(i);
         end
      end
   end

   assign room = count_ff < CNT_W'(MAX_TASKS);
   assign at_leaf = depth_ff == n_ff;
   assign depth_m1 = depth_ff - CNT_W'(1);
   assign back_idx = trial_ff[depth_m1[IDX_W-1:0]];
   assign prod = PROD_W'(elapsed_ff[depth_ff]) * PROD_W'(fine_ff[pick_idx]);

   assign status.search_done = !at_leaf && !pick_found && (depth_ff == '0);
   assign status.emit_end = (CNT_W'(emit_ff) + CNT_W'(1)) == n_ff;

   assign out_number = NUM_W'(best_ff[emit_ff]);
   assign out_cost = best_cost_ff;
   assign out_last = status.emit_end;

   always_comb begin
      dur_in = dur_ff;
      fine_in = fine_ff;
      count_in = count_ff;
      n_in = n_ff;
      depth_in = depth_ff;
      cand_in = cand_ff;
      used_in = used_ff;
      trial_in = trial_ff;
      best_in = best_ff;
      elapsed_in = elapsed_ff;
      total_in = total_ff;
      best_cost_in = best_cost_ff;
      first_in = first_ff;
      emit_in = emit_ff;
      if (cmd.store && room) begin
         dur_in[count_ff[IDX_W-1:0]] = in_duration;
         fine_in[count_ff[IDX_W-1:0]] = in_fine;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.start) begin
         n_in = room ? count_ff + CNT_W'(1) : count_ff;
         count_in = '0;
         depth_in = '0;
         cand_in = '0;
         used_in = '0;
         elapsed_in[0] = '0;
         total_in[0] = '0;
         first_in = 1'b1;
         emit_in = '0;
      end
      if (cmd.step) begin
         if (at_leaf) begin
            if (first_ff || (total_ff[depth_ff] < best_cost_ff)) begin
               best_cost_in = total_ff[depth_ff];
               best_in = trial_ff;
            end
            first_in = 1'b0;
         end
         if (!at_leaf && pick_found) begin
            used_in[pick_idx] = 1'b1;
            trial_in[depth_ff[IDX_W-1:0]] = pick_idx;
            elapsed_in[depth_ff + CNT_W'(1)] =
               elapsed_ff[depth_ff] + EL_W'(dur_ff[pick_idx]);
            total_in[depth_ff + CNT_W'(1)] = total_ff[depth_ff] + COST_W'(prod);
            depth_in = depth_ff + CNT_W'(1);
            cand_in = '0;
         end else if (depth_ff != '0) begin
            used_in[back_idx] = 1'b0;
            depth_in = depth_m1;
            cand_in = CNT_W'(back_idx) + CNT_W'(1);
         end
      end
      if (cmd.emit_next) begin
         emit_in = emit_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         n_ff <= '0;
         depth_ff <= '0;
         cand_ff <= '0;
         used_ff <= '0;
         first_ff <= 1'b0;
         emit_ff <= '0;
         best_cost_ff <= '0;
      end else begin
         count_ff <= count_in;
         n_ff <= n_in;
         depth_ff <= depth_in;
         cand_ff <= cand_in;
         used_ff <= used_in;
         first_ff <= first_in;
         emit_ff <= emit_in;
         best_cost_ff <= best_cost_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff <= dur_in;
      fine_ff <= fine_in;
      trial_ff <= trial_in;
      best_ff <= best_in;
      elapsed_ff <= elapsed_in;
      total_ff <= total_in;
   end

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> depth_ff <= n_ff)
      else $error("search depth beyond task count");
   a_used_matches_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> $countones(used_ff) == int'(depth_ff))
      else $error("used marks disagree with search depth");
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (depth_ff == '0) && (used_ff == '0) && (count_ff == '0))
      else $error("search did not start clean");
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_next |-> CNT_W'(emit_ff) < n_ff)
      else $error("emit position beyond task count");
`endif

endmodule

### test/min_weighted_delay_task_order_test.sv
`timescale 1ns / 1ps

module min_weighted_delay_task_order_test;
   import mwdto_pkg::*;

   localparam int TASK_SLOTS = MAX_TASKS_DEFAULT;
   localparam int RANDOM_TASKS = 84;
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct {
      logic [NUM_W-1:0]  task_number;
      logic [COST_W-1:0] total_fine;
      logic              last_in_order;
   } slot_type;

   class schedule_book;
      logic [DATA_W-1:0] durations[TASK_SLOTS];
      logic [DATA_W-1:0] fines[TASK_SLOTS];
      int                trial[TASK_SLOTS];
      int                best[TASK_SLOTS];
      int                stored;
      slot_type          expected_slots[$];
      int                failures;
      int                sets;
      int                slots_checked;

      function new();
         stored = 0;
         failures = 0;
         sets = 0;
         slots_checked = 0;
      endfunction

      function longint unsigned trial_fine(int n);
         longint unsigned elapsed;
         longint unsigned total;
         elapsed = 0;
         total = 0;
         for (int i = 0; i < n; i++) begin
            total += elapsed * fines[trial[i]];
            elapsed += durations[trial[i]];
         end
         return total;
      endfunction

      // Steps the trial order to its lexicographic successor.
      function bit advance_trial(int n);
         int i;
         int j;
         int tmp;
         int lo;
         int hi;
         i = n - 2;
         while (i >= 0 && trial[i] >= trial[i + 1]) i--;
         if (i < 0) return 0;
         j = n - 1;
         while (trial[j] <= trial[i]) j--;
         tmp = trial[i];
         trial[i] = trial[j];
         trial[j] = tmp;
         lo = i + 1;
         hi = n - 1;
         while (lo < hi) begin
            tmp = trial[lo];
            trial[lo] = trial[hi];
            trial[hi] = tmp;
            lo++;
            hi--;
         end
         return 1;
      endfunction

      // Orders are visited in lexicographic order and only a strictly lower
      // fine replaces the best one, so ties keep the earliest order.
      function void plan_schedule();
         longint unsigned best_fine;
         longint unsigned fine_now;
         slot_type        slot;
         int              n;
         n = stored;
         for (int k = 0; k < TASK_SLOTS; k++) begin
            trial[k] = k;
            best[k] = k;
         end
         best_fine = trial_fine(n);
         while (advance_trial(n)) begin
            fine_now = trial_fine(n);
            if (fine_now < best_fine) begin
               best_fine = fine_now;
               best = trial;
            end
         end
         for (int k = 0; k < n; k++) begin
            slot.task_number = best[k][NUM_W-1:0];
            slot.total_fine = best_fine[COST_W-1:0];
            slot.last_in_order = (k == n - 1);
            expected_slots.push_back(slot);
         end
         stored = 0;
         sets++;
      endfunction

      // Tasks beyond the capacity are dropped, but their last mark still counts.
      function void note_task(logic [DATA_W-1:0] duration, logic [DATA_W-1:0] fine,
                              logic last);
         if (stored < TASK_SLOTS) begin
            durations[stored] = duration;
            fines[stored] = fine;
            stored++;
         end
         if (last) plan_schedule();
      endfunction

      function void check_slot(logic [RSP_DATA_W-1:0] data, logic last);
         slot_type want;
         if (expected_slots.size() == 0) begin
            $error("Unexpected result item: task_number %0d total_fine %0d last %0b",
                   data[NUM_W-1:0], data[NUM_W +: COST_W], last);
            failures++;
            return;
         end
         want = expected_slots.pop_front();
         slots_checked++;
         if (data[NUM_W-1:0] !== want.task_number) begin
            $error("task_number mismatch: expected %0d, actual %0d",
                   want.task_number, data[NUM_W-1:0]);
            failures++;
         end
         if (data[NUM_W +: COST_W] !== want.total_fine) begin
            $error("total_fine mismatch: expected %0d, actual %0d",
                   want.total_fine, data[NUM_W +: COST_W]);
            failures++;
         end
         if (last !== want.last_in_order) begin
            $error("last_in_order mismatch: expected %0b, actual %0b",
                   want.last_in_order, last);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   schedule_book book;
   int           phase = 0;
   int           tasks_sent = 0;
   int           directed_tasks = 0;
   longint       cycle_count = 0;

   min_weighted_delay_task_order dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit roll(int percent);
      return $urandom_range(0, 99) < percent;
   endfunction

   function automatic logic [DATA_W-1:0] random_field();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return DATA_W'($urandom_range(0, 3));
         default: return DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_task(input logic [DATA_W-1:0] duration,
                            input logic [DATA_W-1:0] fine, input logic last);
      int idle_percent;
      idle_percent = (phase == 1) ? 62 : (phase == 3) ? 34 : 0;
      @(negedge clock);
      while (roll(idle_percent)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {fine, duration};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      book.note_task(duration, fine, last);
      tasks_sent++;
   endtask

   always @(negedge clock) begin
      rsp_tready <= !roll((phase == 2) ? 62 : (phase == 3) ? 34 : 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_slot(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d result items outstanding.",
                  cycle_count, book.expected_slots.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int set_size;
      book = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_task('1, '1, 1'b1);
      for (int k = 0; k < 3; k++) send_task('0, '0, k == 2);
      send_task(16'd9, 16'd0, 1'b0);
      send_task(16'd1, 16'hFFFF, 1'b0);
      send_task(16'd300, 16'd12, 1'b0);
      send_task(16'hFFFF, 16'd1, 1'b1);
      // Ten tasks in one set: the last two overflow the store.
      for (int k = 0; k < 10; k++) begin
         if (k < TASK_SLOTS) send_task(random_field(), random_field(), 1'b0);
         else if (k == 8) send_task('1, '1, 1'b0);
         else send_task('0, '0, 1'b1);
      end
      directed_tasks = tasks_sent;

      while (tasks_sent - directed_tasks < RANDOM_TASKS) begin
         phase = (tasks_sent - directed_tasks) / (RANDOM_TASKS / 4);
         if (phase > 3) phase = 3;
         set_size = ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(1, 6);
         for (int k = 0; k < set_size; k++)
            send_task(random_field(), random_field(), k == set_size - 1);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (book.expected_slots.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Sent %0d directed and %0d random tasks in %0d sets.",
               directed_tasks, tasks_sent - directed_tasks, book.sets);
      $display("Checked %0d order positions over %0d cycles.",
               book.slots_checked, cycle_count);
      if (book.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
